// ===== hw/rtl/wrf_pkg.sv =====
// ----------------------------------------------------------------------------
// wrf_pkg
// Shared types and constants of the 3x3 rank / average filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrf_pkg;

   // filter modes
   localparam logic [2:0] MODE_MEDIAN  = 3'd0;
   localparam logic [2:0] MODE_MEAN    = 3'd1;
   localparam logic [2:0] MODE_MINIMUM = 3'd2;
   localparam logic [2:0] MODE_MAXIMUM = 3'd3;
   localparam logic [2:0] MODE_RANGE   = 3'd4;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [2:0]  MODE_RESET   = 3'd0;
   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   // floor(x / 9) = (x * 7282) >> 16 for x below 2296
   localparam logic [12:0] MEAN_RECIP = 13'd7282;

   // result queue
   localparam int RQ_DEPTH = 32;
   localparam int RQ_AW    = 5;
   localparam logic [RQ_AW:0] RQ_ROOM = 6'd20;
   // results held back before release, and released per input
   localparam logic [4:0] HOLD_MAX = 5'd16;
   localparam logic [4:0] OUT_MAX  = 5'd4;

   typedef struct packed {
      logic [31:0] pix;
      logic [10:0] col;
      logic [11:0] row;
   } res_entry_type;

endpackage

// ===== hw/rtl/window_3x3_rank_average_filter_core.sv =====
// ----------------------------------------------------------------------------
// window_3x3_rank_average_filter_core
// 3x3 median / mean / min / max / range filter over a raster RGBA stream,
// with border copying and row / column tagged results.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | one pixel: red, green, blue, alpha
//  rsp_    | out       | one result pixel with row, column, tlast per input
//  csr_    | in / out  | mode, image_width, image_height at 0x0, 0x4, 0x8
//
//  one pixel per cycle for inner pixels; a border pixel that repeats into
//  n results holds the input until its extra copies are written (one result
//  queue write per cycle).
//  the line stores are one dual-ported memory (read at accept, written on
//  advance). synchronous reset clears counters and queues, no memory pass.
//  input stalls when the result queue holds more than 20 entries.
`timescale 1ns / 1ps

module window_3x3_rank_average_filter_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_tvalid,
   output logic        req_tready,
   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_row [11:0], out_col [22:12], out_red [30:23], out_green [38:31],
   // out_blue [46:39], out_alpha [54:47], zero [55]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast
);
   import wrf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
      logic [7:0] lo, md, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c < lo) begin
         md = lo;
         lo = c;
      end else if (c > hi) begin
         md = hi;
         hi = c;
      end else begin
         md = c;
      end
      return {hi, md, lo};
   endfunction

   // ---------------- configuration ----------------
   logic [2:0]  mode_ff;
   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_MODE:   mode_ff   <= csr_pwdata[2:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[11:0];
            REG_HEIGHT: height_ff <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_MODE:   csr_prdata = {29'd0, mode_ff};
         REG_WIDTH:  csr_prdata = {20'd0, width_ff};
         REG_HEIGHT: csr_prdata = {19'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   logic [31:0]   w_full, h_full;
   logic [WW-1:0] w_sz;
   logic [HW-1:0] h_sz;

   always_comb begin
      w_full = {20'd0, width_ff};
      if (w_full < 32'd3) w_full = 32'd3;
      if (w_full > 32'(MAX_WIDTH)) w_full = 32'(MAX_WIDTH);
      h_full = {19'd0, height_ff};
      if (h_full < 32'd3) h_full = 32'd3;
      if (h_full > 32'(MAX_HEIGHT)) h_full = 32'(MAX_HEIGHT);
      w_sz = w_full[WW-1:0];
      h_sz = h_full[HW-1:0];
   end

   // ---------------- stage 0: position, line store read ----------------
   logic          adv;
   logic          accept;
   logic [3:0]    gen_left_ff, gen_left_in;
   logic [RQ_AW:0] rq_count_ff;
   logic [CW-1:0] col_ff, col_in, c0;
   logic [RW-1:0] row_ff, row_in, r0;

   assign adv        = (gen_left_ff == 4'd0) && (rq_count_ff <= RQ_ROOM);
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   always_comb begin
      c0 = (WW'(col_ff) >= w_sz) ? CW'(w_sz - WW'(1)) : col_ff;
      r0 = (HW'(row_ff) >= h_sz) ? RW'(h_sz - HW'(1)) : row_ff;
      if (WW'(c0) + WW'(1) >= w_sz) begin
         col_in = '0;
         row_in = (HW'(r0) + HW'(1) >= h_sz) ? '0 : RW'(r0 + RW'(1));
      end else begin
         col_in = CW'(c0 + CW'(1));
         row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // [63:32] older row, [31:0] newer row
   logic [63:0]   line_mem [MAX_WIDTH];
   logic [63:0]   rd_ff;
   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic [31:0]   s1_pix_ff;

   always_ff @(posedge clock) begin
      if (accept) rd_ff <= line_mem[c0];
      if (adv && s1_valid_ff) line_mem[s1_col_ff] <= {rd_ff[31:0], s1_pix_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff <= c0;
         s1_row_ff <= r0;
         s1_pix_ff <= req_tdata;
      end
   end

   // ---------------- stage 1: window shift ----------------
   logic [23:0]   win_ff [9];
   logic [7:0]    alpha_ff;
   logic          s2_valid_ff;
   logic [CW-1:0] s2_col_ff;
   logic [RW-1:0] s2_row_ff;
   logic [7:0]    s2_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
         alpha_ff    <= '0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i*3]   <= win_ff[i*3+1];
               win_ff[i*3+1] <= win_ff[i*3+2];
            end
            win_ff[2] <= rd_ff[55:32];
            win_ff[5] <= rd_ff[23:0];
            win_ff[8] <= s1_pix_ff[23:0];
            alpha_ff  <= rd_ff[31:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_alpha_ff <= alpha_ff;
      end
   end

   // ---------------- stage 2: column sorts and sums ----------------
   logic [7:0]    s3_lo_ff [3][3];
   logic [7:0]    s3_md_ff [3][3];
   logic [7:0]    s3_hi_ff [3][3];
   logic [9:0]    s3_sum_ff [3][3];
   logic          s3_valid_ff;
   logic [CW-1:0] s3_col_ff;
   logic [RW-1:0] s3_row_ff;
   logic [7:0]    s3_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      logic [23:0] srt;
      logic [7:0]  va, vb, vc;
      if (adv) begin
         s3_col_ff   <= s2_col_ff;
         s3_row_ff   <= s2_row_ff;
         s3_alpha_ff <= s2_alpha_ff;
         for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 3; j++) begin
               va  = win_ff[j][8*ch +: 8];
               vb  = win_ff[3+j][8*ch +: 8];
               vc  = win_ff[6+j][8*ch +: 8];
               srt = sort3(va, vb, vc);
               s3_lo_ff[ch][j]  <= srt[7:0];
               s3_md_ff[ch][j]  <= srt[15:8];
               s3_hi_ff[ch][j]  <= srt[23:16];
               s3_sum_ff[ch][j] <= 10'(va) + 10'(vb) + 10'(vc);
            end
         end
      end
   end

   // ---------------- stage 3: channel results and border copies ----------------
   logic [7:0] chan_res [3];

   always_comb begin
      logic [7:0]  mx_lo, mn_hi, md_md, med, mn, mx;
      logic [23:0] srt_lo, srt_md, srt_hi, srt_mid;
      logic [11:0] tot;
      logic [24:0] prod;
      for (int ch = 0; ch < 3; ch++) begin
         srt_lo  = sort3(s3_lo_ff[ch][0], s3_lo_ff[ch][1], s3_lo_ff[ch][2]);
         srt_md  = sort3(s3_md_ff[ch][0], s3_md_ff[ch][1], s3_md_ff[ch][2]);
         srt_hi  = sort3(s3_hi_ff[ch][0], s3_hi_ff[ch][1], s3_hi_ff[ch][2]);
         mx_lo   = srt_lo[23:16];
         mn      = srt_lo[7:0];
         md_md   = srt_md[15:8];
         mn_hi   = srt_hi[7:0];
         mx      = srt_hi[23:16];
         srt_mid = sort3(mx_lo, md_md, mn_hi);
         med     = srt_mid[15:8];
         tot   = 12'(s3_sum_ff[ch][0]) + 12'(s3_sum_ff[ch][1]) + 12'(s3_sum_ff[ch][2]);
         prod  = 25'(tot) * 25'(MEAN_RECIP);
         case (mode_ff)
            MODE_MEDIAN:  chan_res[ch] = med;
            MODE_MEAN:    chan_res[ch] = prod[23:16];
            MODE_MINIMUM: chan_res[ch] = mn;
            MODE_MAXIMUM: chan_res[ch] = mx;
            MODE_RANGE:   chan_res[ch] = mx - mn;
            default:      chan_res[ch] = 8'd0;
         endcase
      end
   end

   logic [31:0]   s3_pix;
   logic          s3_has;
   logic [RW-1:0] y3;
   logic [CW-1:0] x3;
   logic [11:0]   rows3 [3];
   logic [10:0]   cols3 [3];
   logic [1:0]    nr3, nc3;
   logic [3:0]    k3, kacc;
   logic [4:0]    mq_ff, mq_in, room3, tot3, n3;
   logic          s3_fire;

   assign s3_pix  = {s3_alpha_ff, chan_res[2], chan_res[1], chan_res[0]};
   assign s3_fire = s3_valid_ff && adv;

   always_comb begin
      s3_has = (s3_row_ff >= RW'(2)) && (s3_col_ff >= CW'(2));
      y3 = RW'(s3_row_ff - RW'(1));
      x3 = CW'(s3_col_ff - CW'(1));
      rows3[0] = 12'(y3);
      rows3[1] = '0;
      rows3[2] = '0;
      cols3[0] = 11'(x3);
      cols3[1] = '0;
      cols3[2] = '0;
      nr3 = 2'd1;
      nc3 = 2'd1;
      if (y3 == RW'(1)) begin
         rows3[nr3] = 12'd0;
         nr3 = nr3 + 2'd1;
      end
      if (HW'(y3) == h_sz - HW'(2)) begin
         rows3[nr3] = 12'(h_sz - HW'(1));
         nr3 = nr3 + 2'd1;
      end
      if (x3 == CW'(1)) begin
         cols3[nc3] = 11'd0;
         nc3 = nc3 + 2'd1;
      end
      if (WW'(x3) == w_sz - WW'(2)) begin
         cols3[nc3] = 11'(w_sz - WW'(1));
         nc3 = nc3 + 2'd1;
      end
      k3    = s3_has ? 4'(nr3) * 4'(nc3) : 4'd0;
      room3 = HOLD_MAX - mq_ff;
      // results beyond the hold limit are dropped
      kacc  = (5'(k3) > room3) ? room3[3:0] : k3;
      tot3  = mq_ff + 5'(kacc);
      n3    = (tot3 > OUT_MAX) ? OUT_MAX : tot3;
      mq_in = tot3 - n3;
   end

   always_ff @(posedge clock) begin
      if (reset) mq_ff <= '0;
      else if (s3_fire) mq_ff <= mq_in;
   end

   // copy generator for border results after the first
   logic [1:0]  gen_a_ff, gen_b_ff, gen_a_in, gen_b_in, gen_nc_ff;
   logic [11:0] gen_rows_ff [3];
   logic [10:0] gen_cols_ff [3];
   logic [31:0] gen_pix_ff;
   logic        gen_busy;
   logic        rq_push;
   res_entry_type rq_wdata;

   assign gen_busy = (gen_left_ff != 4'd0);

   always_comb begin
      gen_left_in = gen_left_ff;
      gen_a_in    = gen_a_ff;
      gen_b_in    = gen_b_ff;
      rq_push     = 1'b0;
      rq_wdata    = '{pix: s3_pix, col: cols3[0], row: rows3[0]};
      if (gen_busy) begin
         rq_push     = 1'b1;
         rq_wdata    = '{pix: gen_pix_ff, col: gen_cols_ff[gen_b_ff],
                         row: gen_rows_ff[gen_a_ff]};
         gen_left_in = gen_left_ff - 4'd1;
         if (gen_b_ff + 2'd1 < gen_nc_ff) begin
            gen_b_in = gen_b_ff + 2'd1;
         end else begin
            gen_b_in = 2'd0;
            gen_a_in = gen_a_ff + 2'd1;
         end
      end else if (s3_fire && kacc != 4'd0) begin
         rq_push     = 1'b1;
         gen_left_in = kacc - 4'd1;
         if (nc3 > 2'd1) begin
            gen_a_in = 2'd0;
            gen_b_in = 2'd1;
         end else begin
            gen_a_in = 2'd1;
            gen_b_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) gen_left_ff <= '0;
      else gen_left_ff <= gen_left_in;
   end

   always_ff @(posedge clock) begin
      gen_a_ff <= gen_a_in;
      gen_b_ff <= gen_b_in;
      if (s3_fire) begin
         gen_nc_ff  <= nc3;
         gen_pix_ff <= s3_pix;
         for (int i = 0; i < 3; i++) begin
            gen_rows_ff[i] <= rows3[i];
            gen_cols_ff[i] <= cols3[i];
         end
      end
   end

   // ---------------- result queue and release groups ----------------
   res_entry_type  rq_mem [RQ_DEPTH];
   logic [RQ_AW-1:0] rq_wr_ff, rq_rd_ff;
   logic [1:0]     gq_mem [RQ_DEPTH];
   logic [RQ_AW-1:0] gq_wr_ff, gq_rd_ff;
   logic [RQ_AW:0] gq_count_ff;
   logic [1:0]     out_pos_ff;
   logic           gq_push, rsp_xfer, grp_done;
   res_entry_type  rq_head;

   assign gq_push  = s3_fire && (n3 != 5'd0);
   assign rq_head  = rq_mem[rq_rd_ff];

   assign rsp_tvalid = (rq_count_ff != '0) && (gq_count_ff != '0);
   assign rsp_tlast  = (out_pos_ff == gq_mem[gq_rd_ff]);
   assign rsp_tdata  = {1'b0, rq_head.pix, rq_head.col, rq_head.row};
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign grp_done   = rsp_xfer && rsp_tlast;

   always_ff @(posedge clock) begin
      if (rq_push) rq_mem[rq_wr_ff] <= rq_wdata;
      if (gq_push) gq_mem[gq_wr_ff] <= 2'(n3 - 5'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
         gq_wr_ff    <= '0;
         gq_rd_ff    <= '0;
         gq_count_ff <= '0;
         out_pos_ff  <= '0;
      end else begin
         if (rq_push) rq_wr_ff <= RQ_AW'(rq_wr_ff + 1'b1);
         if (rsp_xfer) rq_rd_ff <= RQ_AW'(rq_rd_ff + 1'b1);
         rq_count_ff <= rq_count_ff + (RQ_AW+1)'(rq_push) - (RQ_AW+1)'(rsp_xfer);
         if (gq_push) gq_wr_ff <= RQ_AW'(gq_wr_ff + 1'b1);
         if (grp_done) gq_rd_ff <= RQ_AW'(gq_rd_ff + 1'b1);
         gq_count_ff <= gq_count_ff + (RQ_AW+1)'(gq_push) - (RQ_AW+1)'(grp_done);
         if (grp_done) out_pos_ff <= '0;
         else if (rsp_xfer) out_pos_ff <= out_pos_ff + 2'd1;
      end
   end

endmodule

// ===== hw/rtl/wrf_checker.sv =====
// ----------------------------------------------------------------------------
// wrf_checker
// Port-level checks of the 3x3 filter core, bound to the core module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_pready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);

   // queues come out of reset empty
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tlast)))
      else $error("stalled result changed");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("csr pready dropped");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[55])
      else $error("result pad bit set");

endmodule

bind window_3x3_rank_average_filter_core wrf_checker u_wrf_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_pready (csr_pready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
